// ===== hw/rtl/plm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and codes for the posting-list merge block and its table cells.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int DOC_W  = 16;
  localparam int TF_W   = 16;
  localparam int FREQ_W = 32;

  // item opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ELEM  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // combine operators
  localparam logic [1:0] MODE_AND = 2'd0;
  localparam logic [1:0] MODE_OR  = 2'd1;
  localparam logic [1:0] MODE_NOT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COMPACT
  } state_t;

  typedef enum logic [2:0] {
    CC_NONE,
    CC_OR,
    CC_AND,
    CC_NOT,
    CC_BUMP,
    CC_SHIFT
  } cell_cmd_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_cmd_t         cmd;
    logic              clr_mark;      // list opens: marks start from zero
    logic              append;        // write the element into the selected cell
    logic              drop_on_mark;  // compaction drops marked (1) or unmarked (0)
    logic [DOC_W-1:0]  doc;
    logic [TF_W-1:0]   freq;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/plm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plm_cell
// One accumulator table entry: id, frequency and mark, with its own compare,
// saturating adder and a left-shift path from the next cell.
// ----------------------------------------------------------------------------
module plm_cell (
  input  logic                         clk,
  input  plm_pkg::cell_ctl_t           ctl,
  input  logic                         valid,    // entry is below the count
  input  logic                         sel,      // entry sits at the count
  input  logic [plm_pkg::DOC_W-1:0]    nxt_doc,
  input  logic [plm_pkg::FREQ_W-1:0]   nxt_freq,
  input  logic                         nxt_mark,
  input  logic                         hit_in,
  input  logic                         pfx_in,
  output logic [plm_pkg::DOC_W-1:0]    doc,
  output logic [plm_pkg::FREQ_W-1:0]   freq,
  output logic                         mark,
  output logic                         hit_out,
  output logic                         pfx_out
);

  logic [plm_pkg::DOC_W-1:0]  doc_r, doc_nxt;
  logic [plm_pkg::FREQ_W-1:0] freq_r, freq_nxt;
  logic                       mark_r, mark_nxt;
  logic                       match, mark_cur, drop;
  logic [plm_pkg::FREQ_W:0]   add_sum, inc_sum;
  logic [plm_pkg::FREQ_W-1:0] add_sat, inc_sat;

  assign match    = valid && (doc_r == ctl.doc);
  assign mark_cur = ctl.clr_mark ? 1'b0 : mark_r;
  assign drop     = valid && (mark_r == ctl.drop_on_mark);
  assign hit_out  = hit_in | match;
  assign pfx_out  = pfx_in | drop;

  assign add_sum = {1'b0, freq_r} + {{(plm_pkg::FREQ_W + 1 - plm_pkg::TF_W){1'b0}}, ctl.freq};
  assign inc_sum = {1'b0, freq_r} + {{plm_pkg::FREQ_W{1'b0}}, 1'b1};
  assign add_sat = add_sum[plm_pkg::FREQ_W] ? '1 : add_sum[plm_pkg::FREQ_W-1:0];
  assign inc_sat = inc_sum[plm_pkg::FREQ_W] ? '1 : inc_sum[plm_pkg::FREQ_W-1:0];

  always_comb begin
    doc_nxt  = doc_r;
    freq_nxt = freq_r;
    mark_nxt = mark_cur;
    if (ctl.append && sel) begin
      doc_nxt  = ctl.doc;
      freq_nxt = {{(plm_pkg::FREQ_W - plm_pkg::TF_W){1'b0}}, ctl.freq};
      mark_nxt = 1'b0;
    end else begin
      case (ctl.cmd)
        plm_pkg::CC_OR: begin
          // only the first matching entry in the row takes the add
          if (match && !hit_in) freq_nxt = add_sat;
        end
        plm_pkg::CC_AND: begin
          if (match && !mark_cur) begin
            mark_nxt = 1'b1;
            freq_nxt = add_sat;
          end
        end
        plm_pkg::CC_NOT: begin
          if (match) mark_nxt = 1'b1;
        end
        plm_pkg::CC_BUMP: begin
          if (valid && !mark_r) freq_nxt = inc_sat;
        end
        plm_pkg::CC_SHIFT: begin
          // everything from the first dropped entry up moves down one place
          if (pfx_out) begin
            doc_nxt  = nxt_doc;
            freq_nxt = nxt_freq;
            mark_nxt = nxt_mark;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    doc_r  <= doc_nxt;
    freq_r <= freq_nxt;
    mark_r <= mark_nxt;
  end

  assign doc  = doc_r;
  assign freq = freq_r;
  assign mark = mark_r;

endmodule

// ===== hw/rtl/posting_list_boolean_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posting_list_boolean_merge
// Accumulator table of (document id, frequency) entries that folds term lists
// in with AND, OR or NOT, built as a row of table cells.
// ----------------------------------------------------------------------------
// Each word is accepted in IDLE and then executed in EXEC, where every
// cell compares the element id in parallel and updates itself once the
// output register is free; one result word leaves per input word through
// an output register, so a new word is taken while the last result waits.
// The end of an AND or NOT list that was not copied into an empty table
// compacts the row: the cells shift down past one dropped entry per cycle.
// The id compare and the first-match and first-drop chains that run along
// the row of MAX_ENTRIES cells set the cycle time.
module posting_list_boolean_merge #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] mode, [17:2] doc_id, [33:18] term_freq, [38:34] read_index
  input  logic [39:0] in_tdata,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] out_doc_id, [47:16] out_freq, [53:48] entry_count, [54] overflow
  output logic [55:0] out_tdata,
  // [0] entry_valid
  output logic        out_tuser
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int DW    = plm_pkg::DOC_W;
  localparam int FW    = plm_pkg::FREQ_W;

  plm_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               list_open_r, list_open_nxt;
  logic               copy_r, copy_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic               ovf_r, ovf_nxt;

  // accepted word
  logic [1:0]         item_op_r;
  logic [1:0]         item_mode_r;
  logic [DW-1:0]      item_doc_r;
  logic [15:0]        item_tf_r;
  logic [4:0]         item_ridx_r;

  // result word
  logic               out_valid_r, out_valid_nxt;
  logic [DW-1:0]      res_doc_r;
  logic [FW-1:0]      res_freq_r;
  logic               res_ev_r;
  logic [5:0]         res_cnt_r;
  logic               res_ovf_r;

  plm_pkg::cell_ctl_t ctl;
  logic               done, out_free, full, opening, eff_copy, do_append;
  logic [1:0]         eff_mode;
  logic [DW-1:0]      rd_doc;
  logic [FW-1:0]      rd_freq;
  logic               rd_valid;
  logic [CNT_W+5:0]   cnt_ext;

  logic [DW-1:0]      cdoc  [MAX_ENTRIES+1];
  logic [FW-1:0]      cfreq [MAX_ENTRIES+1];
  logic               cmark [MAX_ENTRIES+1];
  logic               hit_c [MAX_ENTRIES+1];
  logic               pfx_c [MAX_ENTRIES+1];

  assign cdoc[MAX_ENTRIES]  = '0;
  assign cfreq[MAX_ENTRIES] = '0;
  assign cmark[MAX_ENTRIES] = 1'b0;
  assign hit_c[0] = 1'b0;
  assign pfx_c[0] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    plm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .valid    (CNT_W'(i) < count_r),
      .sel      (CNT_W'(i) == count_r),
      .nxt_doc  (cdoc[i+1]),
      .nxt_freq (cfreq[i+1]),
      .nxt_mark (cmark[i+1]),
      .hit_in   (hit_c[i]),
      .pfx_in   (pfx_c[i]),
      .doc      (cdoc[i]),
      .freq     (cfreq[i]),
      .mark     (cmark[i]),
      .hit_out  (hit_c[i+1]),
      .pfx_out  (pfx_c[i+1])
    );
  end

  // read port: one-hot pick of the addressed cell
  always_comb begin
    rd_doc   = '0;
    rd_freq  = '0;
    rd_valid = 32'(item_ridx_r) < 32'(count_r);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (rd_valid && (32'(item_ridx_r) == i)) begin
        rd_doc  = cdoc[i];
        rd_freq = cfreq[i];
      end
    end
  end

  assign in_tready = (state_r == plm_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (count_r == CNT_W'(MAX_ENTRIES));
  assign opening   = (item_op_r == plm_pkg::OP_ELEM) && !list_open_r;
  assign eff_mode  = opening ? item_mode_r : mode_r;
  assign eff_copy  = opening ? (count_r == '0) : copy_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    list_open_nxt = list_open_r;
    copy_nxt      = copy_r;
    mode_nxt      = mode_r;
    ovf_nxt       = ovf_r;
    done          = 1'b0;
    do_append     = 1'b0;
    ctl.cmd          = plm_pkg::CC_NONE;
    ctl.clr_mark     = 1'b0;
    ctl.append       = 1'b0;
    ctl.drop_on_mark = (mode_r == plm_pkg::MODE_NOT);
    ctl.doc          = item_doc_r;
    ctl.freq         = item_tf_r;

    case (state_r)
      plm_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = plm_pkg::ST_EXEC;
      end
      plm_pkg::ST_EXEC: begin
        if (out_free) begin
          case (item_op_r)
            plm_pkg::OP_CLEAR: begin
              count_nxt     = '0;
              list_open_nxt = 1'b0;
              copy_nxt      = 1'b0;
              ovf_nxt       = 1'b0;
              done          = 1'b1;
            end
            plm_pkg::OP_ELEM: begin
              list_open_nxt = 1'b1;
              mode_nxt      = eff_mode;
              copy_nxt      = eff_copy;
              ctl.clr_mark  = opening;
              if (eff_copy) begin
                do_append = (eff_mode == plm_pkg::MODE_AND) ||
                            (eff_mode == plm_pkg::MODE_OR) ||
                            (eff_mode == plm_pkg::MODE_NOT);
              end else begin
                case (eff_mode)
                  plm_pkg::MODE_OR: begin
                    ctl.cmd   = plm_pkg::CC_OR;
                    do_append = !hit_c[MAX_ENTRIES];
                  end
                  plm_pkg::MODE_AND: ctl.cmd = plm_pkg::CC_AND;
                  plm_pkg::MODE_NOT: ctl.cmd = plm_pkg::CC_NOT;
                  default: begin
                  end
                endcase
              end
              if (do_append) begin
                if (full) begin
                  ovf_nxt = 1'b1;
                end else begin
                  ctl.append = 1'b1;
                  count_nxt  = count_r + CNT_W'(1);
                end
              end
              done = 1'b1;
            end
            plm_pkg::OP_END: begin
              if (list_open_r && !copy_r &&
                  (mode_r == plm_pkg::MODE_AND || mode_r == plm_pkg::MODE_NOT)) begin
                // NOT survivors gain one before the row is compacted
                if (mode_r == plm_pkg::MODE_NOT) ctl.cmd = plm_pkg::CC_BUMP;
                state_nxt = plm_pkg::ST_COMPACT;
              end else begin
                list_open_nxt = 1'b0;
                copy_nxt      = 1'b0;
                done          = 1'b1;
              end
            end
            plm_pkg::OP_READ: begin
              done = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      plm_pkg::ST_COMPACT: begin
        ctl.cmd = plm_pkg::CC_SHIFT;
        if (pfx_c[MAX_ENTRIES]) begin
          count_nxt = count_r - CNT_W'(1);
        end else if (out_free) begin
          list_open_nxt = 1'b0;
          copy_nxt      = 1'b0;
          done          = 1'b1;
        end
      end
      default: begin
        state_nxt = plm_pkg::ST_IDLE;
      end
    endcase

    if (done) state_nxt = plm_pkg::ST_IDLE;

    if (done)            out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  assign cnt_ext = {6'b0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plm_pkg::ST_IDLE;
      count_r     <= '0;
      list_open_r <= 1'b0;
      copy_r      <= 1'b0;
      mode_r      <= plm_pkg::MODE_AND;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_open_r <= list_open_nxt;
      copy_r      <= copy_nxt;
      mode_r      <= mode_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_op_r   <= in_tuser;
      item_mode_r <= in_tdata[1:0];
      item_doc_r  <= in_tdata[17:2];
      item_tf_r   <= in_tdata[33:18];
      item_ridx_r <= in_tdata[38:34];
    end
    if (done) begin
      res_ev_r   <= (item_op_r == plm_pkg::OP_READ) && rd_valid;
      res_doc_r  <= (item_op_r == plm_pkg::OP_READ) ? rd_doc : '0;
      res_freq_r <= (item_op_r == plm_pkg::OP_READ) ? rd_freq : '0;
      res_cnt_r  <= cnt_ext[5:0];
      res_ovf_r  <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_ovf_r, res_cnt_r, res_freq_r, res_doc_r};
  assign out_tuser  = res_ev_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_compact_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plm_pkg::ST_COMPACT) |-> (list_open_r && !copy_r))
    else $error("compaction without an open merged list");

  a_copy_open: assert property (@(posedge clk) disable iff (!rst_n)
    copy_r |-> list_open_r)
    else $error("copy pending on a closed list");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plm_pkg::ST_EXEC && out_free && item_op_r == plm_pkg::OP_CLEAR)
    |=> (count_r == '0 && !ovf_r && out_valid_r))
    else $error("clear did not empty the table");

endmodule

// ===== bench/posting_list_boolean_merge_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posting_list_boolean_merge_tb
// Self-checking bench for the posting-list merge block: a directed run through
// copy, OR, AND, NOT, the ignored operator, stray ends and clears, then random
// term lists, reads and noise. Both stream sides idle at random, the receiver
// holds off long enough to back the block up, and a scoreboard predicts every
// result word from its own copy of the accumulator table.
// ----------------------------------------------------------------------------

localparam int TABLE_DEPTH = 32;

typedef logic [plm_pkg::DOC_W-1:0]  doc_t;
typedef logic [plm_pkg::TF_W-1:0]   tf_t;
typedef logic [plm_pkg::FREQ_W-1:0] freq_t;

typedef struct packed {
  logic [1:0]  op;
  logic [1:0]  mode;
  doc_t        doc;
  tf_t         tf;
  logic [4:0]  ridx;
} term_word_t;

typedef struct packed {
  doc_t        doc;
  freq_t       freq;
  logic        valid;
  logic [5:0]  entries;
  logic        ovf;
} merge_result_t;

class merge_scoreboard;
  doc_t              tbl_doc  [TABLE_DEPTH];
  freq_t             tbl_freq [TABLE_DEPTH];
  bit                tbl_mark [TABLE_DEPTH];
  int unsigned       n_entries;
  bit                list_open;
  bit                copy_pending;
  bit                overflow_flag;
  logic [1:0]        list_mode;
  merge_result_t     expected_q[$];

  int mismatches;
  int checked;
  int valid_reads;
  int lists_by_mode[4];
  int peak_entries;
  bit overflow_seen;

  function new();
    n_entries     = 0;
    list_open     = 0;
    copy_pending  = 0;
    overflow_flag = 0;
    list_mode     = plm_pkg::MODE_AND;
    mismatches    = 0;
    checked       = 0;
    valid_reads   = 0;
    peak_entries  = 0;
    overflow_seen = 0;
    foreach (tbl_mark[i]) tbl_mark[i] = 0;
    foreach (lists_by_mode[i]) lists_by_mode[i] = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function freq_t sat_add(freq_t a, freq_t b);
    logic [plm_pkg::FREQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[plm_pkg::FREQ_W] ? '1 : s[plm_pkg::FREQ_W-1:0];
  endfunction

  function void clear_marks();
    foreach (tbl_mark[i]) tbl_mark[i] = 0;
  endfunction

  function void append(doc_t doc, freq_t freq);
    if (n_entries >= TABLE_DEPTH) begin
      overflow_flag = 1;
      overflow_seen = 1;
      return;
    end
    tbl_doc[n_entries]  = doc;
    tbl_freq[n_entries] = freq;
    tbl_mark[n_entries] = 0;
    n_entries++;
    if (n_entries > peak_entries) peak_entries = n_entries;
  endfunction

  // keep entries whose mark matches, order preserved; NOT survivors gain one
  function void compact(bit keep_mark, bit bump);
    int unsigned wr;
    wr = 0;
    for (int unsigned rd = 0; rd < n_entries; rd++) begin
      if (tbl_mark[rd] == keep_mark) begin
        tbl_doc[wr]  = tbl_doc[rd];
        tbl_freq[wr] = bump ? sat_add(tbl_freq[rd], 32'd1) : tbl_freq[rd];
        wr++;
      end
    end
    n_entries = wr;
  endfunction

  function void fold_element(doc_t doc, tf_t tf);
    freq_t f;
    f = freq_t'(tf);
    if (copy_pending) begin
      if (list_mode <= plm_pkg::MODE_NOT) append(doc, f);
      return;
    end
    case (list_mode)
      plm_pkg::MODE_OR: begin
        for (int unsigned i = 0; i < n_entries; i++) begin
          if (tbl_doc[i] == doc) begin
            tbl_freq[i] = sat_add(tbl_freq[i], f);
            return;
          end
        end
        append(doc, f);
      end
      plm_pkg::MODE_AND: begin
        for (int unsigned i = 0; i < n_entries; i++) begin
          if (tbl_doc[i] == doc && !tbl_mark[i]) begin
            tbl_mark[i] = 1;
            tbl_freq[i] = sat_add(tbl_freq[i], f);
          end
        end
      end
      plm_pkg::MODE_NOT: begin
        for (int unsigned i = 0; i < n_entries; i++)
          if (tbl_doc[i] == doc) tbl_mark[i] = 1;
      end
      default: ;
    endcase
  endfunction

  function void note_word(term_word_t w);
    merge_result_t r;
    r = '0;
    case (w.op)
      plm_pkg::OP_CLEAR: begin
        n_entries     = 0;
        list_open     = 0;
        copy_pending  = 0;
        overflow_flag = 0;
        clear_marks();
      end
      plm_pkg::OP_ELEM: begin
        if (!list_open) begin
          list_open    = 1;
          list_mode    = w.mode;
          copy_pending = (n_entries == 0);
          lists_by_mode[w.mode]++;
          clear_marks();
        end
        fold_element(w.doc, w.tf);
      end
      plm_pkg::OP_END: begin
        if (list_open) begin
          if (!copy_pending) begin
            if (list_mode == plm_pkg::MODE_AND) compact(1'b1, 1'b0);
            else if (list_mode == plm_pkg::MODE_NOT) compact(1'b0, 1'b1);
          end
          clear_marks();
          list_open    = 0;
          copy_pending = 0;
        end
      end
      default: begin
        if (w.ridx < n_entries) begin
          r.doc   = tbl_doc[w.ridx];
          r.freq  = tbl_freq[w.ridx];
          r.valid = 1'b1;
          valid_reads++;
        end
      end
    endcase
    r.entries = n_entries[5:0];
    r.ovf     = overflow_flag;
    expected_q = {expected_q, r};
  endfunction

  task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h", $time, checked, field,
             got, want);
    mismatches++;
  endtask

  task check_result(logic [55:0] tdata, logic tuser);
    merge_result_t e;
    if (expected_q.size() == 0) begin
      report_mismatch("word with nothing pending", tdata[31:0], 32'd0);
      return;
    end
    e = expected_q.pop_front();
    if (tdata[15:0] !== e.doc)
      report_mismatch("doc_id", 32'(tdata[15:0]), 32'(e.doc));
    if (tdata[47:16] !== e.freq)
      report_mismatch("freq", tdata[47:16], e.freq);
    if (tuser !== e.valid)
      report_mismatch("entry_valid", 32'(tuser), 32'(e.valid));
    if (tdata[53:48] !== e.entries)
      report_mismatch("entry_count", 32'(tdata[53:48]), 32'(e.entries));
    if (tdata[54] !== e.ovf)
      report_mismatch("overflow", 32'(tdata[54]), 32'(e.ovf));
    checked++;
  endtask
endclass

module posting_list_boolean_merge_tb;

  localparam logic [1:0] MODE_NONE = 2'd3;  // operator that ignores its list
  localparam int RANDOM_WORDS = 1650;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tuser;

  merge_scoreboard sb;
  doc_t id_pool[8];
  int  words_sent;
  int  rx_hold;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  quiet;

  posting_list_boolean_merge #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_word(input logic [1:0] op, input logic [1:0] mode,
                           input doc_t doc, input tf_t tf,
                           input logic [4:0] ridx);
    term_word_t w;
    int gap;
    w.op   = op;
    w.mode = mode;
    w.doc  = doc;
    w.tf   = tf;
    w.ridx = ridx;
    if (tx_idle_on && !quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {1'b0, ridx, tf, doc, mode};
    in_tuser  = op;
    do @(posedge clk); while (!in_tready);
    sb.note_word(w);
    words_sent++;
    if ($urandom_range(0, 59) == 0) tx_idle_on = !tx_idle_on;
    if ($urandom_range(0, 59) == 0) rx_idle_on = !rx_idle_on;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic doc_t pick_doc();
    if (sb.n_entries > 0 && $urandom_range(0, 1) == 1)
      return sb.tbl_doc[$urandom_range(0, sb.n_entries - 1)];
    return id_pool[$urandom_range(0, 7)];
  endfunction

  function automatic tf_t pick_tf();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return tf_t'($urandom_range(1, 20));
      default: return tf_t'($urandom);
    endcase
  endfunction

  task automatic send_read(input logic [4:0] ridx);
    send_word(plm_pkg::OP_READ, 2'($urandom), doc_t'($urandom), tf_t'($urandom), ridx);
  endtask

  // one term list: the first word latches the operator, later mode fields are don't-care
  task automatic send_list(input logic [1:0] mode, input int len, input bit fresh,
                           input bit close);
    doc_t doc;
    for (int i = 0; i < len; i++) begin
      doc = fresh ? doc_t'($urandom) : pick_doc();
      send_word(plm_pkg::OP_ELEM, (i == 0) ? mode : 2'($urandom), doc, pick_tf(),
                5'($urandom));
    end
    if (close) send_word(plm_pkg::OP_END, 2'($urandom), doc_t'($urandom), tf_t'($urandom),
                         5'($urandom));
  endtask

  // receiver: random stall bursts plus one long hold-off requested by the sender side
  initial begin
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready = 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        if (rx_idle_on && !quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 10);
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  initial begin
    #8_000_000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int directed_words;
    int sel;
    int r;
    bit held;
    bit paused;
    logic [1:0] m;

    sb         = new();
    words_sent = 0;
    rx_hold    = 0;
    tx_idle_on = 1;
    rx_idle_on = 1;
    quiet      = 0;
    held       = 0;
    paused     = 0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = plm_pkg::OP_CLEAR;
    rst_n      = 1'b0;
    foreach (id_pool[i]) id_pool[i] = doc_t'($urandom);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty reads, stray end, copy under NOT, OR, AND repeats, NOT, ignored op
    send_read(5'd0);
    send_word(plm_pkg::OP_END, plm_pkg::MODE_AND, '0, '0, '0);
    send_word(plm_pkg::OP_ELEM, plm_pkg::MODE_NOT, 16'h0000, 16'h0000, 5'd0);
    send_word(plm_pkg::OP_ELEM, plm_pkg::MODE_AND, 16'hFFFF, 16'hFFFF, 5'd31);
    send_word(plm_pkg::OP_ELEM, MODE_NONE, 16'h1234, 16'd7, 5'd0);
    send_word(plm_pkg::OP_END, plm_pkg::MODE_OR, '0, '0, '0);
    send_read(5'd0);
    send_read(5'd1);
    send_read(5'd2);
    send_read(5'd3);
    send_read(5'd31);
    send_word(plm_pkg::OP_ELEM, plm_pkg::MODE_OR, 16'hFFFF, 16'd1, '0);
    send_word(plm_pkg::OP_ELEM, plm_pkg::MODE_AND, 16'h5555, 16'd2, '0);
    send_word(plm_pkg::OP_END, plm_pkg::MODE_OR, '0, '0, '0);
    send_word(plm_pkg::OP_ELEM, plm_pkg::MODE_AND, 16'h1234, 16'd3, '0);
    send_word(plm_pkg::OP_ELEM, plm_pkg::MODE_AND, 16'h1234, 16'd5, '0);
    send_word(plm_pkg::OP_ELEM, plm_pkg::MODE_OR, 16'hFFFF, 16'd4, '0);
    send_word(plm_pkg::OP_END, plm_pkg::MODE_AND, '0, '0, '0);
    send_word(plm_pkg::OP_ELEM, plm_pkg::MODE_NOT, 16'hFFFF, 16'd9, '0);
    send_word(plm_pkg::OP_END, plm_pkg::MODE_NOT, '0, '0, '0);
    send_word(plm_pkg::OP_ELEM, MODE_NONE, 16'h0001, 16'd1, '0);
    send_word(plm_pkg::OP_END, MODE_NONE, '0, '0, '0);
    send_read(5'd0);
    send_word(plm_pkg::OP_CLEAR, plm_pkg::MODE_OR, '1, '1, '1);
    send_read(5'd0);
    directed_words = words_sent;

    while (words_sent - directed_words < RANDOM_WORDS) begin
      if (words_sent - directed_words >= RANDOM_WORDS - 150) quiet = 1;
      if (!held && words_sent - directed_words >= 400) begin
        held    = 1;
        rx_hold = 300;
      end
      if (!paused && words_sent - directed_words >= 900) begin
        paused = 1;
        drop_valid();
        wait_drained();
      end
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        send_word(plm_pkg::OP_CLEAR, 2'($urandom), doc_t'($urandom), tf_t'($urandom),
                  5'($urandom));
      end else if (sel < 66) begin
        r = $urandom_range(0, 19);
        m = (r < 6) ? plm_pkg::MODE_AND : (r < 12) ? plm_pkg::MODE_OR :
            (r < 18) ? plm_pkg::MODE_NOT : MODE_NONE;
        if ($urandom_range(0, 14) == 0)
          send_list(plm_pkg::MODE_OR, $urandom_range(20, 40), 1'b1, 1'b1);
        else
          send_list(m, $urandom_range(1, 8), 1'b0, $urandom_range(0, 19) != 0);
        repeat ($urandom_range(0, 3)) send_read(5'($urandom_range(0, sb.n_entries)));
      end else if (sel < 86) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) send_read(5'($urandom));
          else send_read(5'($urandom_range(0, sb.n_entries)));
        end
      end else begin
        send_word(2'($urandom), 2'($urandom), doc_t'($urandom), tf_t'($urandom),
                  5'($urandom));
      end
    end

    drop_valid();
    wait_drained();
    repeat (60) @(posedge clk);
    $display("Ran %0d words, checked %0d results, %0d reads hit a live entry",
             words_sent, sb.checked, sb.valid_reads);
    $display("Lists opened AND/OR/NOT/ignored: %0d/%0d/%0d/%0d, peak fill %0d, overflow %s",
             sb.lists_by_mode[0], sb.lists_by_mode[1], sb.lists_by_mode[2],
             sb.lists_by_mode[3], sb.peak_entries, sb.overflow_seen ? "hit" : "not hit");
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/plm_pkg.sv
hw/rtl/plm_cell.sv
hw/rtl/posting_list_boolean_merge.sv
bench/posting_list_boolean_merge_tb.sv
